// ----- sv/afk_pkg.sv -----
// Shared constants, types and functions for the arm kinematics block.
`timescale 1ns / 1ps

package afk_pkg;

   // Default widths
   localparam int TRIG_BITS_DEF        = 16;
   localparam int LENGTH_FRAC_BITS_DEF = 8;
   localparam int GUARD_BITS           = 8;

   // Field widths
   localparam int ANG_W = 8;
   localparam int DEG_W = 9;   // reduced angle 0..359
   localparam int LEN_W = 16;
   localparam int POS_W = 19;
   localparam int NUM_LINKS = 3;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam int POS_MAX = 262143;
   localparam int POS_MIN = -262144;

   // Register indexes
   localparam logic [7:0] REG_UPPER_LINK  = 8'd0;
   localparam logic [7:0] REG_LOWER_LINK  = 8'd1;
   localparam logic [7:0] REG_GRIPPER     = 8'd2;
   localparam logic [7:0] REG_BASE_HEIGHT = 8'd3;

   // Reduced joint angles carried down the chain
   typedef struct packed {
      logic [NUM_LINKS-1:0][DEG_W-1:0] joint;
      logic [ANG_W-1:0]                base;
   } afk_ang_type;

   // Quadrant fold of a reduced angle
   typedef struct packed {
      logic       neg;
      logic [6:0] idx;
   } afk_fold_type;

   // Quarter-wave sine entry, Q30 Taylor series rounded to tb fraction bits
   function automatic logic [63:0] quarter_sin(int unsigned d, int unsigned tb);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic signed [63:0] sum;
      int unsigned        k;
      x   = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
      x2  = (x * x) >> 30;
      t   = x;
      sum = $signed(x);
      for (k = 1; k <= 12; k++) begin
         t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if ((k & 1) != 0) begin
            sum = sum - $signed(t);
         end else begin
            sum = sum + $signed(t);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (sum > (64'sd1 <<< 30)) begin
         sum = 64'sd1 <<< 30;
      end
      return (64'(sum) + (64'd1 << (29 - tb))) >> (30 - tb);
   endfunction

   // Length in hundredths of a millimetre to length units, saturating
   function automatic logic [LEN_W-1:0] length_reset(int unsigned hundredths,
                                                      int unsigned lfb);
      logic [63:0] v;
      v = ((64'(hundredths) << lfb) + 64'd50) / 64'd100;
      return (v > 64'd65535) ? 16'hFFFF : v[LEN_W-1:0];
   endfunction

   // Fold a 0..359 angle onto the quarter wave
   function automatic afk_fold_type fold_angle(logic [DEG_W-1:0] r);
      afk_fold_type f;
      logic [DEG_W-1:0] m;
      if (r <= 9'd90) begin
         m = r;
         f.neg = 1'b0;
      end else if (r <= 9'd180) begin
         m = 9'd180 - r;
         f.neg = 1'b0;
      end else if (r <= 9'd270) begin
         m = r - 9'd180;
         f.neg = 1'b1;
      end else begin
         m = 9'd360 - r;
         f.neg = 1'b1;
      end
      f.idx = m[6:0];
      return f;
   endfunction

   // Cosine angle: r + 90 modulo 360
   function automatic logic [DEG_W-1:0] cos_angle(logic [DEG_W-1:0] r);
      logic [DEG_W:0] s;
      s = {1'b0, r} + 10'd90;
      if (s >= 10'd360) begin
         s = s - 10'd360;
      end
      return s[DEG_W-1:0];
   endfunction

endpackage

// ----- sv/afk_if.sv -----
// Request and response channel interfaces for the arm kinematics block.
`timescale 1ns / 1ps

interface afk_req_if;
   logic                        valid;
   logic                        ready;
   logic [afk_pkg::ANG_W-1:0]   base_angle;
   logic [afk_pkg::ANG_W-1:0]   shoulder_angle;
   logic [afk_pkg::ANG_W-1:0]   elbow_angle;
   logic [afk_pkg::ANG_W-1:0]   wrist_angle;

   modport source (output valid, base_angle, shoulder_angle, elbow_angle, wrist_angle,
                   input ready);
   modport sink   (input valid, base_angle, shoulder_angle, elbow_angle, wrist_angle,
                   output ready);
endinterface

interface afk_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [afk_pkg::POS_W-1:0]  x_pos;
   logic signed [afk_pkg::POS_W-1:0]  y_pos;
   logic signed [afk_pkg::POS_W-1:0]  z_pos;

   modport source (output valid, x_pos, y_pos, z_pos, input ready);
   modport sink   (input valid, x_pos, y_pos, z_pos, output ready);
endinterface

// ----- sv/afk_sin_rom.sv -----
// Quarter-wave sine table lookup for a reduced angle in whole degrees.
`timescale 1ns / 1ps

module afk_sin_rom #(
   parameter int TRIG_BITS = afk_pkg::TRIG_BITS_DEF
) (
   input  logic [afk_pkg::DEG_W-1:0]  angle,
   output logic signed [TRIG_BITS+1:0] sin_val
);

   logic [TRIG_BITS:0]    tab [0:90];
   afk_pkg::afk_fold_type fold;
   logic [TRIG_BITS+1:0]  mag;

   // Constant table built at elaboration
   for (genvar d = 0; d <= 90; d++) begin : g_tab
      assign tab[d] = (TRIG_BITS+1)'(afk_pkg::quarter_sin(d, TRIG_BITS));
   end

   // Fold by quadrant and apply sign
   always_comb begin
      fold    = afk_pkg::fold_angle(angle);
      mag     = {1'b0, tab[fold.idx]};
      sin_val = fold.neg ? -$signed(mag) : $signed(mag);
   end

endmodule

// ----- sv/afk_cell.sv -----
// One link cell: adds length*cos and length*sin of its joint angle to the running sums.
`timescale 1ns / 1ps

module afk_cell #(
   parameter int TRIG_BITS = afk_pkg::TRIG_BITS_DEF,
   parameter int IDX       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  afk_pkg::afk_ang_type          in_ang,
   input  logic signed [TRIG_BITS+19:0]  in_racc,
   input  logic signed [TRIG_BITS+19:0]  in_zacc,
   input  logic [afk_pkg::LEN_W-1:0]     len,
   output logic                          out_valid,
   output afk_pkg::afk_ang_type          out_ang,
   output logic signed [TRIG_BITS+19:0]  out_racc,
   output logic signed [TRIG_BITS+19:0]  out_zacc
);

   localparam int ACC_W = TRIG_BITS + 20;
   localparam int SIN_W = TRIG_BITS + 2;

   logic [afk_pkg::DEG_W-1:0] ang_s;
   logic [afk_pkg::DEG_W-1:0] ang_c;
   logic signed [SIN_W-1:0]   sin_val;
   logic signed [SIN_W-1:0]   cos_val;

   logic                      v1_ff;
   afk_pkg::afk_ang_type      ang1_ff;
   logic signed [ACC_W-1:0]   racc1_ff;
   logic signed [ACC_W-1:0]   zacc1_ff;
   logic signed [SIN_W-1:0]   sin_ff;
   logic signed [SIN_W-1:0]   cos_ff;

   logic                      v2_ff;
   afk_pkg::afk_ang_type      ang2_ff;
   logic signed [ACC_W-1:0]   racc2_ff;
   logic signed [ACC_W-1:0]   zacc2_ff;
   logic signed [ACC_W-1:0]   racc2_in;
   logic signed [ACC_W-1:0]   zacc2_in;
   logic signed [ACC_W-1:0]   len_ext;

   assign ang_s = in_ang.joint[IDX];
   assign ang_c = afk_pkg::cos_angle(ang_s);

   afk_sin_rom #(.TRIG_BITS(TRIG_BITS)) u_sin (.angle(ang_s), .sin_val(sin_val));
   afk_sin_rom #(.TRIG_BITS(TRIG_BITS)) u_cos (.angle(ang_c), .sin_val(cos_val));

   // Stage 1: table lookup
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang1_ff  <= in_ang;
         racc1_ff <= in_racc;
         zacc1_ff <= in_zacc;
         sin_ff   <= sin_val;
         cos_ff   <= cos_val;
      end
   end

   // Stage 2: multiply and accumulate
   always_comb begin
      len_ext  = ACC_W'($signed({1'b0, len}));
      racc2_in = racc1_ff + len_ext * ACC_W'(cos_ff);
      zacc2_in = zacc1_ff + len_ext * ACC_W'(sin_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang2_ff  <= ang1_ff;
         racc2_ff <= racc2_in;
         zacc2_ff <= zacc2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_ang   = ang2_ff;
   assign out_racc  = racc2_ff;
   assign out_zacc  = zacc2_ff;

endmodule

// ----- sv/afk_post.sv -----
// Output stage: rounds the reach, rotates by the base angle, rounds and saturates x, y, z.
`timescale 1ns / 1ps

module afk_post #(
   parameter int TRIG_BITS = afk_pkg::TRIG_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [afk_pkg::ANG_W-1:0]          in_base,
   input  logic signed [TRIG_BITS+19:0]       in_racc,
   input  logic signed [TRIG_BITS+19:0]       in_zacc,
   output logic                               out_valid,
   output logic signed [afk_pkg::POS_W-1:0]   out_x,
   output logic signed [afk_pkg::POS_W-1:0]   out_y,
   output logic signed [afk_pkg::POS_W-1:0]   out_z
);

   localparam int ACC_W = TRIG_BITS + 20;
   localparam int SIN_W = TRIG_BITS + 2;
   localparam int RCH_W = 27;
   localparam int RS_SH = TRIG_BITS - afk_pkg::GUARD_BITS;
   localparam int XP_W  = TRIG_BITS + 30;
   localparam int XS_W  = XP_W + 1;
   localparam int XS_SH = TRIG_BITS + afk_pkg::GUARD_BITS;
   localparam int ZS_W  = ACC_W + 1;

   localparam logic signed [ZS_W-1:0] R_HALF = ZS_W'(1) <<< (RS_SH - 1);
   localparam logic signed [ZS_W-1:0] Z_HALF = ZS_W'(1) <<< (TRIG_BITS - 1);
   localparam logic signed [ZS_W-1:0] Z_ONE  = ZS_W'(1);
   localparam logic signed [ZS_W-1:0] Z_MAX  = ZS_W'(afk_pkg::POS_MAX);
   localparam logic signed [ZS_W-1:0] Z_MIN  = ZS_W'(afk_pkg::POS_MIN);
   localparam logic signed [XS_W-1:0] X_HALF = XS_W'(1) <<< (XS_SH - 1);
   localparam logic signed [XS_W-1:0] X_ONE  = XS_W'(1);
   localparam logic signed [XS_W-1:0] X_MAX  = XS_W'(afk_pkg::POS_MAX);
   localparam logic signed [XS_W-1:0] X_MIN  = XS_W'(afk_pkg::POS_MIN);

   logic [afk_pkg::DEG_W-1:0] base_s;
   logic [afk_pkg::DEG_W-1:0] base_c;
   logic signed [SIN_W-1:0]   bsin;
   logic signed [SIN_W-1:0]   bcos;

   logic signed [ZS_W-1:0]    rs_sum;
   logic signed [ZS_W-1:0]    zs_sum;
   logic signed [ZS_W-1:0]    zs_sat;
   logic signed [RCH_W-1:0]   reach_in;
   logic signed [afk_pkg::POS_W-1:0] z1_in;

   logic                      v1_ff;
   logic signed [RCH_W-1:0]   reach_ff;
   logic signed [SIN_W-1:0]   bsin_ff;
   logic signed [SIN_W-1:0]   bcos_ff;
   logic signed [afk_pkg::POS_W-1:0] z1_ff;

   logic                      v2_ff;
   logic signed [XP_W-1:0]    xprod_ff;
   logic signed [XP_W-1:0]    yprod_ff;
   logic signed [afk_pkg::POS_W-1:0] z2_ff;

   logic signed [XS_W-1:0]    xs_sum;
   logic signed [XS_W-1:0]    ys_sum;
   logic signed [XS_W-1:0]    xs_val;
   logic signed [XS_W-1:0]    ys_val;
   logic signed [afk_pkg::POS_W-1:0] x3_in;
   logic signed [afk_pkg::POS_W-1:0] y3_in;

   logic                      v3_ff;
   logic signed [afk_pkg::POS_W-1:0] x3_ff;
   logic signed [afk_pkg::POS_W-1:0] y3_ff;
   logic signed [afk_pkg::POS_W-1:0] z3_ff;

   assign base_s = {1'b0, in_base};
   assign base_c = afk_pkg::cos_angle(base_s);

   afk_sin_rom #(.TRIG_BITS(TRIG_BITS)) u_bsin (.angle(base_s), .sin_val(bsin));
   afk_sin_rom #(.TRIG_BITS(TRIG_BITS)) u_bcos (.angle(base_c), .sin_val(bcos));

   // Stage 1: round reach to guard bits, round and clamp z
   always_comb begin
      rs_sum = ZS_W'(in_racc) + R_HALF;
      if (in_racc < 0) begin
         rs_sum = rs_sum - Z_ONE;
      end
      rs_sum   = rs_sum >>> RS_SH;
      reach_in = RCH_W'(rs_sum);

      zs_sum = ZS_W'(in_zacc) + Z_HALF;
      if (in_zacc < 0) begin
         zs_sum = zs_sum - Z_ONE;
      end
      zs_sum = zs_sum >>> TRIG_BITS;
      if (zs_sum > Z_MAX) begin
         zs_sat = Z_MAX;
      end else if (zs_sum < Z_MIN) begin
         zs_sat = Z_MIN;
      end else begin
         zs_sat = zs_sum;
      end
      z1_in = afk_pkg::POS_W'(zs_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         reach_ff <= reach_in;
         bsin_ff  <= bsin;
         bcos_ff  <= bcos;
         z1_ff    <= z1_in;
      end
   end

   // Stage 2: base rotation products
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xprod_ff <= XP_W'(reach_ff) * XP_W'(bcos_ff);
         yprod_ff <= XP_W'(reach_ff) * XP_W'(bsin_ff);
         z2_ff    <= z1_ff;
      end
   end

   // Stage 3: round, negate x, saturate
   always_comb begin
      xs_sum = XS_W'(xprod_ff) + X_HALF;
      if (xprod_ff < 0) begin
         xs_sum = xs_sum - X_ONE;
      end
      xs_val = -(xs_sum >>> XS_SH);

      ys_sum = XS_W'(yprod_ff) + X_HALF;
      if (yprod_ff < 0) begin
         ys_sum = ys_sum - X_ONE;
      end
      ys_val = ys_sum >>> XS_SH;

      if (xs_val > X_MAX) begin
         x3_in = afk_pkg::POS_W'(X_MAX);
      end else if (xs_val < X_MIN) begin
         x3_in = afk_pkg::POS_W'(X_MIN);
      end else begin
         x3_in = afk_pkg::POS_W'(xs_val);
      end

      if (ys_val > X_MAX) begin
         y3_in = afk_pkg::POS_W'(X_MAX);
      end else if (ys_val < X_MIN) begin
         y3_in = afk_pkg::POS_W'(X_MIN);
      end else begin
         y3_in = afk_pkg::POS_W'(ys_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x3_ff <= x3_in;
         y3_ff <= y3_in;
         z3_ff <= z2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_x     = x3_ff;
   assign out_y     = y3_ff;
   assign out_z     = z3_ff;

endmodule

// ----- sv/arm_forward_kinematics.sv -----
// Pipeline: an accepted word passes the angle stage, three link cells of two stages each
// and three output stages before its result shows on rsp.
// Throughput: one word per cycle; the whole pipeline advances when the output
// register is empty or being taken, so a result waiting on rsp stalls every stage.
// Reset: synchronous, clears all stage valid bits and loads the link lengths and
// base height with their default values.
`timescale 1ns / 1ps

module arm_forward_kinematics #(
   parameter int TRIG_BITS        = afk_pkg::TRIG_BITS_DEF,
   parameter int LENGTH_FRAC_BITS = afk_pkg::LENGTH_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   afk_req_if.sink                    req_chan,
   afk_rsp_if.source                  rsp_chan,
   input  logic                       csr_we,
   input  logic [7:0]                 csr_index,
   input  logic [afk_pkg::LEN_W-1:0]  csr_wdata
);

   localparam int ACC_W = TRIG_BITS + 20;
   localparam int NL    = afk_pkg::NUM_LINKS;

   localparam logic [afk_pkg::LEN_W-1:0] UPPER_RST =
      afk_pkg::length_reset(14605, LENGTH_FRAC_BITS);
   localparam logic [afk_pkg::LEN_W-1:0] LOWER_RST =
      afk_pkg::length_reset(21590, LENGTH_FRAC_BITS);
   localparam logic [afk_pkg::LEN_W-1:0] GRIP_RST =
      afk_pkg::length_reset(10000, LENGTH_FRAC_BITS);
   localparam logic [afk_pkg::LEN_W-1:0] HEIGHT_RST =
      afk_pkg::length_reset(6985, LENGTH_FRAC_BITS);

   // Configuration registers
   logic [afk_pkg::LEN_W-1:0] upper_ff;
   logic [afk_pkg::LEN_W-1:0] lower_ff;
   logic [afk_pkg::LEN_W-1:0] grip_ff;
   logic [afk_pkg::LEN_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= UPPER_RST;
         lower_ff  <= LOWER_RST;
         grip_ff   <= GRIP_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            afk_pkg::REG_UPPER_LINK:  upper_ff  <= csr_wdata;
            afk_pkg::REG_LOWER_LINK:  lower_ff  <= csr_wdata;
            afk_pkg::REG_GRIPPER:     grip_ff   <= csr_wdata;
            afk_pkg::REG_BASE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline advance
   logic en;
   logic out_valid;

   assign en             = !out_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   // Angle stage: elbow and wrist link angles reduced to 0..359
   logic signed [10:0]   e_raw;
   logic signed [10:0]   w_raw;
   logic [8:0]           e_red;
   logic [8:0]           w_red;
   afk_pkg::afk_ang_type ang0_in;

   always_comb begin
      e_raw = 11'(req_chan.shoulder_angle) + 11'(req_chan.elbow_angle) - 11'sd180;
      if (e_raw < 0) begin
         e_raw = e_raw + 11'sd360;
      end
      e_red = e_raw[8:0];
      w_raw = 11'(req_chan.wrist_angle) + 11'(e_red) - 11'sd90;
      if (w_raw < 0) begin
         w_raw = w_raw + 11'sd360;
      end else if (w_raw >= 11'sd360) begin
         w_raw = w_raw - 11'sd360;
      end
      w_red = w_raw[8:0];
      ang0_in.joint[0] = {1'b0, req_chan.shoulder_angle};
      ang0_in.joint[1] = e_red;
      ang0_in.joint[2] = w_red;
      ang0_in.base     = req_chan.base_angle;
   end

   logic                      v_c   [0:NL];
   afk_pkg::afk_ang_type      ang_c [0:NL];
   logic signed [ACC_W-1:0]   racc_c [0:NL];
   logic signed [ACC_W-1:0]   zacc_c [0:NL];
   logic [afk_pkg::LEN_W-1:0] len_c [0:NL-1];

   logic                      v0_ff;
   afk_pkg::afk_ang_type      ang0_ff;
   logic signed [ACC_W-1:0]   zacc0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang0_ff  <= ang0_in;
         zacc0_ff <= $signed(ACC_W'(height_ff) << TRIG_BITS);
      end
   end

   assign v_c[0]    = v0_ff;
   assign ang_c[0]  = ang0_ff;
   assign racc_c[0] = '0;
   assign zacc_c[0] = zacc0_ff;
   assign len_c[0]  = upper_ff;
   assign len_c[1]  = lower_ff;
   assign len_c[2]  = grip_ff;

   // Link cells
   for (genvar i = 0; i < NL; i++) begin : g_cell
      afk_cell #(.TRIG_BITS(TRIG_BITS), .IDX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (v_c[i]),
         .in_ang    (ang_c[i]),
         .in_racc   (racc_c[i]),
         .in_zacc   (zacc_c[i]),
         .len       (len_c[i]),
         .out_valid (v_c[i+1]),
         .out_ang   (ang_c[i+1]),
         .out_racc  (racc_c[i+1]),
         .out_zacc  (zacc_c[i+1])
      );
   end

   // Base rotation and output register
   afk_post #(.TRIG_BITS(TRIG_BITS)) u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_c[NL]),
      .in_base   (ang_c[NL].base),
      .in_racc   (racc_c[NL]),
      .in_zacc   (zacc_c[NL]),
      .out_valid (out_valid),
      .out_x     (rsp_chan.x_pos),
      .out_y     (rsp_chan.y_pos),
      .out_z     (rsp_chan.z_pos)
   );

   assign rsp_chan.valid = out_valid;

`ifndef NO_ASSERTIONS
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_chan.valid)
      else $error("result valid right after reset");

   a_no_take_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while output stalled");

   a_cfg_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (upper_ff == UPPER_RST && height_ff == HEIGHT_RST))
      else $error("configuration not at reset value");

   a_stall_holds_cells: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> $stable(v_c[NL]))
      else $error("chain advanced during stall");
`endif

endmodule

// ----- test/tb_arm_forward_kinematics.sv -----
// Testbench for arm_forward_kinematics: random and directed angle words checked against a predictor.
`timescale 1ns / 1ps

module tb_arm_forward_kinematics;

   localparam int TRIG_FRAC  = 16;
   localparam int GUARD      = 8;
   localparam int DRAIN      = 14;
   localparam int CYCLE_CAP  = 400000;
   localparam int RAND_ITEMS = 1100;
   localparam int HOLD_LEN   = 300;

   typedef struct {
      logic signed [afk_pkg::POS_W-1:0] x;
      logic signed [afk_pkg::POS_W-1:0] y;
      logic signed [afk_pkg::POS_W-1:0] z;
   } point_type;

   // Scoreboard: link geometry, sine table and the queue of expected gripper points
   class kinematics_board_type;
      longint     sine_tab [0:90];
      longint     upper_len, lower_len, grip_len, height;
      point_type  points_due [$];
      int         errors;

      function new();
         longint unsigned xa, xsq, term;
         longint          acc;
         for (int d = 0; d <= 90; d++) begin
            xa   = (longint'(d) * 64'd3373259426 + 90) / 180;
            xsq  = (xa * xa) >> 30;
            term = xa;
            acc  = xa;
            for (int k = 1; k <= 12; k++) begin
               term = ((term * xsq) >> 30) / longint'((2 * k) * (2 * k + 1));
               if (k % 2 == 1) begin
                  acc = acc - longint'(term);
               end else begin
                  acc = acc + longint'(term);
               end
            end
            if (acc < 0) acc = 0;
            if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
            sine_tab[d] = (acc + (64'sd1 <<< (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC);
         end
         set_defaults();
         errors = 0;
      endfunction

      function void set_defaults();
         upper_len = 37389;
         lower_len = 55270;
         grip_len  = 25600;
         height    = 17882;
      endfunction

      function void write_reg(int idx, longint val);
         unique case (idx)
            afk_pkg::REG_UPPER_LINK:  upper_len = val & 16'hFFFF;
            afk_pkg::REG_LOWER_LINK:  lower_len = val & 16'hFFFF;
            afk_pkg::REG_GRIPPER:     grip_len  = val & 16'hFFFF;
            afk_pkg::REG_BASE_HEIGHT: height    = val & 16'hFFFF;
            default: ;
         endcase
      endfunction

      function longint sine(int d);
         int r;
         r = ((d % 360) + 360) % 360;
         if (r <= 90) return sine_tab[r];
         if (r <= 180) return sine_tab[180 - r];
         if (r <= 270) return -sine_tab[r - 180];
         return -sine_tab[360 - r];
      endfunction

      function longint cosine(int d);
         return sine(d + 90);
      endfunction

      // shift right with rounding half away from zero
      function longint shift_round(longint v, int s);
         longint half;
         half = 64'sd1 <<< (s - 1);
         if (v < 0) return -((-v + half) >>> s);
         return (v + half) >>> s;
      endfunction

      function logic signed [afk_pkg::POS_W-1:0] clamp(longint v);
         if (v > afk_pkg::POS_MAX) v = afk_pkg::POS_MAX;
         if (v < afk_pkg::POS_MIN) v = afk_pkg::POS_MIN;
         return v[afk_pkg::POS_W-1:0];
      endfunction

      // note an accepted angle word and work out its gripper point
      function void note_angles(int b, int s, int e_raw, int w_raw);
         int        e, w;
         longint    reach, zsum;
         point_type p;
         e = s + e_raw - 180;
         w = w_raw + e - 90;
         reach = upper_len * cosine(s) + lower_len * cosine(e) + grip_len * cosine(w);
         reach = shift_round(reach, TRIG_FRAC - GUARD);
         zsum  = height * (64'sd1 <<< TRIG_FRAC) + upper_len * sine(s)
                 + lower_len * sine(e) + grip_len * sine(w);
         p.x = clamp(-shift_round(cosine(b) * reach, TRIG_FRAC + GUARD));
         p.y = clamp(shift_round(sine(b) * reach, TRIG_FRAC + GUARD));
         p.z = clamp(shift_round(zsum, TRIG_FRAC));
         points_due.push_back(p);
      endfunction

      function void check_point(logic signed [afk_pkg::POS_W-1:0] x,
                                logic signed [afk_pkg::POS_W-1:0] y,
                                logic signed [afk_pkg::POS_W-1:0] z);
         point_type p;
         if (points_due.size() == 0) begin
            $error("unexpected result word x=%0d y=%0d z=%0d", x, y, z);
            errors++;
            return;
         end
         p = points_due.pop_front();
         if (x !== p.x) begin
            $error("x_pos: expected %0d, actual %0d", p.x, x);
            errors++;
         end
         if (y !== p.y) begin
            $error("y_pos: expected %0d, actual %0d", p.y, y);
            errors++;
         end
         if (z !== p.z) begin
            $error("z_pos: expected %0d, actual %0d", p.z, z);
            errors++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_we = 1'b0;
   logic [7:0]                  csr_index = '0;
   logic [afk_pkg::LEN_W-1:0]   csr_wdata = '0;

   afk_req_if req ();
   afk_rsp_if rsp ();

   kinematics_board_type board = new();
   bit   calm = 1'b0;        // no idling on either side
   int   hold_reqs = 0;      // receiver stalls requested by the sender side
   int   hold_seen = 0;      // receiver stalls started
   int   hold_off = 0;       // receiver stall cycles left
   int   cycles = 0;

   arm_forward_kinematics DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req.sink),
      .rsp_chan  (rsp.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random ready, long hold-off on request, checks accepted words
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         board.check_point(rsp.x_pos, rsp.y_pos, rsp.z_pos);
      end
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp.ready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
         hold_seen <= hold_reqs;
         hold_off  <= HOLD_LEN - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= calm || ($urandom_range(99) >= 34);
      end
   end

   task automatic send_angles(int b, int s, int e, int w);
      if (!calm) begin
         while ($urandom_range(99) < 34) begin
            req.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req.valid <= 1'b1;
      req.base_angle <= afk_pkg::ANG_W'(b);
      req.shoulder_angle <= afk_pkg::ANG_W'(s);
      req.elbow_angle <= afk_pkg::ANG_W'(e);
      req.wrist_angle <= afk_pkg::ANG_W'(w);
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_angles(b, s, e, w);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (board.points_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(int idx, int val);
      csr_we <= 1'b1;
      csr_index <= 8'(idx);
      csr_wdata <= afk_pkg::LEN_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(idx, val);
      @(posedge clock);
   endtask

   function automatic int pick_angle();
      return ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(180);
   endfunction

   task automatic random_words(int n);
      for (int i = 0; i < n; i++) begin
         calm = (i >= n / 3 && i < n / 3 + 80);
         if (i == n / 2) hold_reqs++;
         if (i == (2 * n) / 3) begin
            drain();
         end
         send_angles(pick_angle(), pick_angle(), pick_angle(), pick_angle());
      end
      calm = 1'b0;
   endtask

   initial begin
      req.valid <= 1'b0;
      req.base_angle <= '0;
      req.shoulder_angle <= '0;
      req.elbow_angle <= '0;
      req.wrist_angle <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at reset geometry: range extremes, right angles, out-of-range angles
      send_angles(0, 0, 0, 0);
      send_angles(180, 180, 180, 180);
      send_angles(255, 255, 255, 255);
      send_angles(90, 90, 90, 90);
      send_angles(0, 90, 180, 90);
      send_angles(180, 0, 0, 0);
      send_angles(45, 135, 45, 135);
      send_angles(90, 180, 0, 180);
      send_angles(1, 179, 181, 200);
      send_angles(170, 10, 250, 5);
      send_angles(128, 64, 32, 16);
      send_angles(127, 191, 223, 239);
      drain();

      // all lengths at maximum: saturation
      write_csr(afk_pkg::REG_UPPER_LINK, 16'hFFFF);
      write_csr(afk_pkg::REG_LOWER_LINK, 16'hFFFF);
      write_csr(afk_pkg::REG_GRIPPER, 16'hFFFF);
      write_csr(afk_pkg::REG_BASE_HEIGHT, 16'hFFFF);
      send_angles(0, 90, 180, 90);
      send_angles(180, 90, 180, 90);
      send_angles(90, 0, 180, 270 - 180);
      send_angles(0, 0, 0, 0);
      send_angles(90, 180, 180, 90);
      random_words(RAND_ITEMS / 5);
      drain();

      // all zero, plus writes to unused indexes that must be ignored
      write_csr(afk_pkg::REG_UPPER_LINK, 0);
      write_csr(afk_pkg::REG_LOWER_LINK, 0);
      write_csr(afk_pkg::REG_GRIPPER, 0);
      write_csr(afk_pkg::REG_BASE_HEIGHT, 0);
      write_csr(4, 16'h1234);
      write_csr(255, 16'hFFFF);
      send_angles(37, 90, 90, 90);
      random_words(RAND_ITEMS / 10);
      drain();

      // random geometries
      for (int ph = 0; ph < 3; ph++) begin
         write_csr(afk_pkg::REG_UPPER_LINK, $urandom_range(65535));
         write_csr(afk_pkg::REG_LOWER_LINK, $urandom_range(65535));
         write_csr(afk_pkg::REG_GRIPPER, $urandom_range(65535));
         write_csr(afk_pkg::REG_BASE_HEIGHT, $urandom_range(65535));
         random_words(RAND_ITEMS / 6);
         drain();
      end

      // back to the default geometry for the long mixed run
      write_csr(afk_pkg::REG_UPPER_LINK, 37389);
      write_csr(afk_pkg::REG_LOWER_LINK, 55270);
      write_csr(afk_pkg::REG_GRIPPER, 25600);
      write_csr(afk_pkg::REG_BASE_HEIGHT, 17882);
      random_words(RAND_ITEMS / 5);
      drain();

      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
